/* sv/image_resampler_defines.svh */
// assertion macros shared by the image resampler
`ifndef IMAGE_RESAMPLER_DEFINES_SVH
`define IMAGE_RESAMPLER_DEFINES_SVH

// same-cycle implication
`define RSZ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("image resampler check failed");

// next-cycle implication
`define RSZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("image resampler check failed");

`endif

/* sv/rsz_pkg.sv */
// types, codes and defaults of the image resampler
`default_nettype none
package rsz_pkg;

   localparam int DEF_MAX_SOURCE_WIDTH  = 128;
   localparam int DEF_MAX_SOURCE_HEIGHT = 128;
   localparam int DEF_FRACTION_BITS     = 8;
   localparam int DEF_MAX_TARGET_DIM    = 4096;

   localparam logic [1:0] KIND_LOAD     = 2'd0;
   localparam logic [1:0] KIND_RESAMPLE = 2'd1;
   localparam logic [1:0] KIND_COORD    = 2'd2;

   localparam logic [1:0] MODE_NEAREST  = 2'd0;
   localparam logic [1:0] MODE_BILINEAR = 2'd1;
   localparam logic [1:0] MODE_BICUBIC  = 2'd2;

   localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
   localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
   localparam logic [2:0] REG_MODE          = 3'd4;

   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_CUB_A    = 4'd1;
   localparam logic [3:0] OP_CUB_B    = 4'd2;
   localparam logic [3:0] OP_CUB_C    = 4'd3;
   localparam logic [3:0] OP_ROW      = 4'd4;
   localparam logic [3:0] OP_FIN_CUB  = 4'd5;
   localparam logic [3:0] OP_LIN1     = 4'd6;
   localparam logic [3:0] OP_LIN2     = 4'd7;
   localparam logic [3:0] OP_LIN3     = 4'd8;
   localparam logic [3:0] OP_FIN_LIN  = 4'd9;
   localparam logic [3:0] OP_FIN_NEAR = 4'd10;

   localparam int READ_COUNT = 16;

   typedef struct packed {
      logic       capture;
      logic       store_wr;
      logic       mul;
      logic       div_step;
      logic       clamp;
      logic       use_div;
      logic       rd_en;
      logic [3:0] rd_k;
      logic [3:0] op;
      logic [1:0] row;
      logic       vsel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
   } status_type;

endpackage
`default_nettype wire

/* sv/image_resampler.sv */
// Image resampler top level: controller plus datapath.
// Load word: written to the image store, no result.
// Coordinate sample: clamp, then store reads of the neighborhood, then the nearest,
// bilinear or bicubic filter steps, then result in the output register; one store read a cycle.
// Destination pixel sample: adds a multiply step and a bit-serial division before the clamp.
// Synchronous active-high reset returns control and settings to defaults; the image store is not cleared.
`default_nettype none
module image_resampler import rsz_pkg::*; #(
   parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
   parameter int FRACTION_BITS     = DEF_FRACTION_BITS,
   parameter int MAX_TARGET_DIM    = DEF_MAX_TARGET_DIM
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_pixel_in,
   input  wire logic [11:0] req_target_row,
   input  wire logic [11:0] req_target_col,
   input  wire logic [14:0] req_coord_x,
   input  wire logic [14:0] req_coord_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_sample_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [12:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rsz_ctrl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rsz_datapath #(
      .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
      .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
      .FRACTION_BITS     (FRACTION_BITS),
      .MAX_TARGET_DIM    (MAX_TARGET_DIM)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pixel_in     (req_pixel_in),
      .req_target_row   (req_target_row),
      .req_target_col   (req_target_col),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule
`default_nettype wire

/* sv/rsz_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module rsz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/rsz_datapath.sv */
// datapath: settings, image store, coordinate divider and interpolation unit
`default_nettype none
module rsz_datapath import rsz_pkg::*; #(
   parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
   parameter int FRACTION_BITS     = DEF_FRACTION_BITS,
   parameter int MAX_TARGET_DIM    = DEF_MAX_TARGET_DIM
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic        csr_valid,
   input  wire logic [2:0]  csr_index,
   input  wire logic [12:0] csr_data,
   input  wire logic [7:0]  req_pixel_in,
   input  wire logic [11:0] req_target_row,
   input  wire logic [11:0] req_target_col,
   input  wire logic [14:0] req_coord_x,
   input  wire logic [14:0] req_coord_y,
   output logic      [7:0]  rsp_sample_value
);

   localparam int F     = FRACTION_BITS;
   localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int QW    = 20 + F;
   localparam int CW    = 8 + F;
   localparam int VW    = F + 11;
   localparam int ACW   = 4 * F + 20;
   localparam logic signed [ACW-1:0] RND_ROW = ACW'(1) <<< (2 * F);
   localparam logic signed [ACW-1:0] RND_LIN = ACW'(1) <<< (2 * F - 1);
   localparam logic signed [ACW-1:0] RND_CUB = ACW'(1) <<< (4 * F);

   // settings
   logic [7:0]  src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [12:0] tgt_w_ff, tgt_w_in, tgt_h_ff, tgt_h_in;
   logic [1:0]  mode_ff, mode_in;
   logic [15:0] pos_ff, pos_in;

   logic [7:0]  sw, sh;
   logic [12:0] tw, th;
   logic [15:0] total, pos_next;

   always_comb begin
      sw = (src_w_ff == 8'd0) ? 8'd1 :
           (src_w_ff > MAX_SOURCE_WIDTH) ? 8'(MAX_SOURCE_WIDTH) : src_w_ff;
      sh = (src_h_ff == 8'd0) ? 8'd1 :
           (src_h_ff > MAX_SOURCE_HEIGHT) ? 8'(MAX_SOURCE_HEIGHT) : src_h_ff;
      tw = (tgt_w_ff == 13'd0) ? 13'd1 :
           (tgt_w_ff > MAX_TARGET_DIM) ? 13'(MAX_TARGET_DIM) : tgt_w_ff;
      th = (tgt_h_ff == 13'd0) ? 13'd1 :
           (tgt_h_ff > MAX_TARGET_DIM) ? 13'(MAX_TARGET_DIM) : tgt_h_ff;
      total    = 16'(sw) * 16'(sh);
      pos_next = pos_ff + 16'd1;
   end

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      tgt_w_in = tgt_w_ff;
      tgt_h_in = tgt_h_ff;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      if (cmd.store_wr) begin
         pos_in = (pos_next >= total) ? 16'd0 : pos_next;
      end
      if (csr_valid) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH: begin
               src_w_in = csr_data[7:0];
               pos_in   = 16'd0;
            end
            REG_SOURCE_HEIGHT: begin
               src_h_in = csr_data[7:0];
               pos_in   = 16'd0;
            end
            REG_TARGET_WIDTH:  tgt_w_in = csr_data;
            REG_TARGET_HEIGHT: tgt_h_in = csr_data;
            REG_MODE:          mode_in  = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 8'd128;
         src_h_ff <= 8'd128;
         tgt_w_ff <= 13'd128;
         tgt_h_ff <= 13'd128;
         mode_ff  <= MODE_BILINEAR;
         pos_ff   <= 16'd0;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         tgt_w_ff <= tgt_w_in;
         tgt_h_ff <= tgt_h_in;
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
      end
   end

   assign status.mode = mode_ff;

   // captured word
   logic [11:0] row_ff, col_ff;
   logic [14:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_target_row;
         col_ff <= req_target_col;
         cx_ff  <= req_coord_x;
         cy_ff  <= req_coord_y;
      end
   end

   // restoring divider, x and y lanes side by side
   logic [QW-1:0] n_ff [2];
   logic [12:0]   rem_ff [2];
   logic [12:0]   dvs [2];
   logic [13:0]   rem_sh [2];
   logic          ge [2];

   always_comb begin
      dvs[0] = tw;
      dvs[1] = th;
      for (int l = 0; l < 2; l++) begin
         rem_sh[l] = {rem_ff[l], n_ff[l][QW-1]};
         ge[l]     = rem_sh[l] >= {1'b0, dvs[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         n_ff[0]   <= {20'(col_ff) * 20'(sw - 8'd1), F'(0)};
         n_ff[1]   <= {20'(row_ff) * 20'(sh - 8'd1), F'(0)};
         rem_ff[0] <= 13'd0;
         rem_ff[1] <= 13'd0;
      end else if (cmd.div_step) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[l] <= ge[l] ? 13'(rem_sh[l] - {1'b0, dvs[l]}) : rem_sh[l][12:0];
            n_ff[l]   <= {n_ff[l][QW-2:0], ge[l]};
         end
      end
   end

   // coordinate clamp and split
   logic [QW-1:0] xsrc, ysrc;
   logic [CW-1:0] xmax, ymax, xc, yc;
   logic [CW:0]   xr, yr;
   logic          near;
   logic [7:0]    base_c_ff, base_r_ff;
   logic [F-1:0]  fx_ff, fy_ff;

   always_comb begin
      xsrc = cmd.use_div ? n_ff[0] : QW'(cx_ff);
      ysrc = cmd.use_div ? n_ff[1] : QW'(cy_ff);
      xmax = {sw - 8'd1, F'(0)};
      ymax = {sh - 8'd1, F'(0)};
      xc   = (xsrc > QW'(xmax)) ? xmax : CW'(xsrc);
      yc   = (ysrc > QW'(ymax)) ? ymax : CW'(ysrc);
      xr   = {1'b0, xc} + (CW + 1)'(1 << (F - 1));
      yr   = {1'b0, yc} + (CW + 1)'(1 << (F - 1));
      near = (mode_ff != MODE_BILINEAR) && (mode_ff != MODE_BICUBIC);
   end

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         base_c_ff <= near ? xr[CW-1:F] : xc[CW-1:F];
         base_r_ff <= near ? yr[CW-1:F] : yc[CW-1:F];
         fx_ff     <= xc[F-1:0];
         fy_ff     <= yc[F-1:0];
      end
   end

   // neighborhood read address
   logic signed [9:0] rr, cc;
   logic [7:0]        r8, c8;
   logic [15:0]       rd_addr16;
   logic              off;

   always_comb begin
      off = (mode_ff == MODE_BICUBIC);
      rr  = $signed({2'b00, base_r_ff}) + $signed({8'd0, cmd.rd_k[3:2]})
            - $signed({9'd0, off});
      cc  = $signed({2'b00, base_c_ff}) + $signed({8'd0, cmd.rd_k[1:0]})
            - $signed({9'd0, off});
      if (rr < 0) begin
         r8 = 8'd0;
      end else if (rr > $signed({2'b00, sh - 8'd1})) begin
         r8 = sh - 8'd1;
      end else begin
         r8 = rr[7:0];
      end
      if (cc < 0) begin
         c8 = 8'd0;
      end else if (cc > $signed({2'b00, sw - 8'd1})) begin
         c8 = sw - 8'd1;
      end else begin
         c8 = cc[7:0];
      end
      rd_addr16 = 16'(r8) * 16'(sw) + 16'(c8);
   end

   logic [7:0] rd_data;

   rsz_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_wr),
      .wr_addr (AW'(pos_ff)),
      .wr_data (req_pixel_in),
      .rd_en   (cmd.rd_en),
      .rd_addr (AW'(rd_addr16)),
      .rd_data (rd_data)
   );

   logic       rd_v_ff;
   logic [3:0] rd_kd_ff;
   logic [7:0] p_ff [16];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_kd_ff <= cmd.rd_k;
      if (rd_v_ff) begin
         p_ff[rd_kd_ff] <= rd_data;
      end
   end

   // shared multiply-add
   logic signed [VW-1:0]  rows_ff [4];
   logic signed [ACW-1:0] inner_ff, mid_ff, num_ff;
   logic signed [ACW-1:0] v [4];
   logic signed [ACW-1:0] ca, cb, tt, base, mop, mac;
   logic signed [ACW-1:0] pe0, pe1, pe4, pe5, r1, r2;
   logic signed [ACW-1:0] row_rnd, lin_rnd, cub_rnd;
   logic [F-1:0]          t;

   function automatic logic [7:0] sat8(input logic signed [ACW-1:0] val);
      if (val < 0) begin
         return 8'd0;
      end else if (val > 255) begin
         return 8'd255;
      end
      return val[7:0];
   endfunction

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         v[j] = cmd.vsel ? ACW'(rows_ff[j])
                         : ACW'($signed({1'b0, p_ff[{cmd.row, 2'(j)}]}));
      end
      ca  = (v[0] <<< 1) - ((v[1] <<< 2) + v[1]) + (v[2] <<< 2) - v[3];
      cb  = ((v[1] - v[2]) <<< 1) + (v[1] - v[2]) + v[3] - v[0];
      pe0 = ACW'($signed({1'b0, p_ff[0]}));
      pe1 = ACW'($signed({1'b0, p_ff[1]}));
      pe4 = ACW'($signed({1'b0, p_ff[4]}));
      pe5 = ACW'($signed({1'b0, p_ff[5]}));
      r1  = ACW'(rows_ff[0]);
      r2  = ACW'(rows_ff[1]);
      t   = (cmd.vsel || (cmd.op == OP_LIN3)) ? fy_ff : fx_ff;
      tt  = ACW'($signed({1'b0, t}));
      unique case (cmd.op)
         OP_CUB_A: begin
            base = ca <<< F;
            mop  = cb;
         end
         OP_CUB_B: begin
            base = (v[2] - v[0]) <<< (2 * F);
            mop  = inner_ff;
         end
         OP_CUB_C: begin
            base = v[1] <<< (3 * F + 1);
            mop  = mid_ff;
         end
         OP_LIN1: begin
            base = pe0 <<< F;
            mop  = pe1 - pe0;
         end
         OP_LIN2: begin
            base = pe4 <<< F;
            mop  = pe5 - pe4;
         end
         OP_LIN3: begin
            base = r1 <<< F;
            mop  = r2 - r1;
         end
         default: begin
            base = '0;
            mop  = '0;
         end
      endcase
      mac     = base + tt * mop;
      row_rnd = (num_ff + RND_ROW) >>> (2 * F + 1);
      lin_rnd = (num_ff + RND_LIN) >>> (2 * F);
      cub_rnd = (num_ff + RND_CUB) >>> (4 * F + 1);
   end

   logic [7:0] sample_ff;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_CUB_A:    inner_ff <= mac;
         OP_CUB_B:    mid_ff   <= mac;
         OP_CUB_C:    num_ff   <= mac;
         OP_LIN3:     num_ff   <= mac;
         OP_ROW:      rows_ff[cmd.row] <= VW'(row_rnd);
         OP_LIN1:     rows_ff[0] <= VW'(mac);
         OP_LIN2:     rows_ff[1] <= VW'(mac);
         OP_FIN_CUB:  sample_ff <= sat8(cub_rnd);
         OP_FIN_LIN:  sample_ff <= sat8(lin_rnd);
         OP_FIN_NEAR: sample_ff <= p_ff[0];
         default: ;
      endcase
   end

   assign rsp_sample_value = sample_ff;

endmodule
`default_nettype wire

/* sv/rsz_ctrl.sv */
// controller: sequences load, divide, clamp, neighborhood read and filter steps
`default_nettype none
`include "image_resampler_defines.svh"
module rsz_ctrl import rsz_pkg::*; #(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam int QW    = 20 + FRACTION_BITS;
   localparam int CNT_W = $clog2(QW + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_CLAMP = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_CALC  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             use_div_ff, use_div_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       op;
   logic [2:0]       rw;
   logic             fin, out_busy, fin_go;

   assign out_busy = rsp_valid_ff && rsp_stall;

   // filter step table
   always_comb begin
      rw = 3'(cnt_ff[CNT_W-1:2]);
      unique case (status.mode)
         MODE_BICUBIC: begin
            unique case (cnt_ff[1:0])
               2'd0: op = OP_CUB_A;
               2'd1: op = OP_CUB_B;
               2'd2: op = OP_CUB_C;
               default: op = (rw == 3'd4) ? OP_FIN_CUB : OP_ROW;
            endcase
         end
         MODE_BILINEAR: begin
            priority if (cnt_ff == CNT_W'(0)) begin
               op = OP_LIN1;
            end else if (cnt_ff == CNT_W'(1)) begin
               op = OP_LIN2;
            end else if (cnt_ff == CNT_W'(2)) begin
               op = OP_LIN3;
            end else begin
               op = OP_FIN_LIN;
            end
         end
         default: op = OP_FIN_NEAR;
      endcase
      fin = (op == OP_FIN_CUB) || (op == OP_FIN_LIN) || (op == OP_FIN_NEAR);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      use_div_in   = use_div_ff;
      fin_go       = 1'b0;
      cmd          = '0;
      cmd.op       = OP_NONE;
      cmd.use_div  = use_div_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_LOAD: cmd.store_wr = 1'b1;
                  KIND_RESAMPLE: begin
                     cmd.capture = 1'b1;
                     use_div_in  = 1'b1;
                     state_in    = S_MUL;
                  end
                  KIND_COORD: begin
                     cmd.capture = 1'b1;
                     use_div_in  = 1'b0;
                     state_in    = S_CLAMP;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               cnt_in   = '0;
               state_in = S_CLAMP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            cnt_in    = '0;
            state_in  = S_READ;
         end
         S_READ: begin
            if (cnt_ff == CNT_W'(READ_COUNT)) begin
               cnt_in   = '0;
               state_in = S_CALC;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_k  = cnt_ff[3:0];
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         S_CALC: begin
            cmd.row  = rw[1:0];
            cmd.vsel = (status.mode == MODE_BICUBIC) && (rw == 3'd4);
            if (fin) begin
               if (!out_busy) begin
                  cmd.op   = op;
                  fin_go   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op = op;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = fin_go || out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         use_div_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         use_div_ff   <= use_div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `RSZ_ASSERT_NEXT(a_fin_shows_word, clock, reset, fin_go, rsp_valid_ff)
   `RSZ_ASSERT_NOW(a_fin_needs_free_out, clock, reset, fin_go, !out_busy)
   `RSZ_ASSERT_NOW(a_read_count_bound, clock, reset, state_ff == S_READ,
                   cnt_ff <= CNT_W'(READ_COUNT))
   `RSZ_ASSERT_NEXT(a_resample_divides, clock, reset,
                    !req_stall && req_valid && (req_kind == KIND_RESAMPLE),
                    state_ff == S_MUL)

endmodule
`default_nettype wire
